@@ sv/pswa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, control word layout and saturation helper of the PID unit.
package pswa_pkg;

    localparam int SIG_W  = 16;
    localparam int FRAC   = 16;
    localparam int KW     = 32;
    localparam int KSW    = 17;
    localparam int ACC_W  = 48;
    localparam int EW     = ACC_W + 1;
    localparam int SPLIT  = 24;
    localparam int A_W    = 33;
    localparam int B_W    = 18;
    localparam int P_W    = A_W + B_W;
    localparam int WIDE_W = 70;
    localparam int PC_W   = 4;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] CFG_SP_GAIN  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_PD_GAIN  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_FILT     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_D_GAIN   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_I_GAIN   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TRK_GAIN = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_LO_LIM   = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_HI_LIM   = 3'd7;

    localparam logic [SIG_W-1:0] LO_LIM_RST = {1'b1, {(SIG_W-1){1'b0}}};
    localparam logic [SIG_W-1:0] HI_LIM_RST = {1'b0, {(SIG_W-1){1'b1}}};

    typedef struct packed {
        logic [SIG_W-1:0] setpoint;
        logic [SIG_W-1:0] measurement;
    } t_in_beat;

    typedef struct packed {
        logic [SIG_W-1:0] control;
        logic             clamped;
    } t_out_beat;

    typedef struct packed {
        logic [SIG_W-1:0] control;
        logic             clamped;
    } t_dp_status;

    typedef struct packed {
        logic [KW-1:0]    ksp;
        logic [KW-1:0]    kpd;
        logic [KSW-1:0]   kf;
        logic [KW-1:0]    kd;
        logic [KW-1:0]    ki;
        logic [KSW-1:0]   kt;
        logic [SIG_W-1:0] lo;
        logic [SIG_W-1:0] hi;
    } t_coefs;

    typedef enum logic [2:0] {
        A_KSP, A_KPD, A_KD, A_KI, A_DL, A_DH, A_EL, A_EH
    } t_asel;

    typedef enum logic [2:0] {
        B_R, B_Y, B_RMY, B_KF, B_KT
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_accop;

    typedef enum logic [1:0] {
        SRC_PROD, SRC_STATES, SRC_INTEG
    } t_addsel;

    typedef enum logic [1:0] {
        SH_0, SH_FRAC, SH_SPLIT
    } t_addsh;

    typedef struct packed {
        logic            mul_en;
        t_asel           a_sel;
        t_bsel           b_sel;
        t_accop          acc_op;
        t_addsel         add_sel;
        t_addsh          add_sh;
        logic            wr_v;
        logic            wr_d;
        logic            wr_i;
        logic            jmp_nc;
        logic [PC_W-1:0] jmp_tgt;
        logic            last;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mul_en: 1'b0, a_sel: A_KSP, b_sel: B_R, acc_op: ACC_NOP,
        add_sel: SRC_PROD, add_sh: SH_0, wr_v: 1'b0, wr_d: 1'b0,
        wr_i: 1'b0, jmp_nc: 1'b0, jmp_tgt: '0, last: 1'b0
    };

    // saturate a wide signed value to the 48-bit accumulator range
    function automatic logic [ACC_W-1:0] sat_acc(input logic [WIDE_W-1:0] x);
        logic all_one;
        logic all_zero;
        all_one  = &x[WIDE_W-1:ACC_W-1];
        all_zero = ~(|x[WIDE_W-1:ACC_W-1]);
        if (all_one || all_zero) begin
            return x[ACC_W-1:0];
        end else if (x[WIDE_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ sv/pswa_useq.sv @@
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store and conditional jump.
module pswa_useq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_out_free,
    input  pswa_pkg::t_dp_status  i_status,
    output pswa_pkg::t_uword      o_uw,
    output logic                  o_busy,
    output logic                  o_done
);

    localparam int PCW = pswa_pkg::PC_W;
    localparam logic [PCW-1:0] PC_INT_WB = 4'd10;

    logic             r_busy;
    logic             n_busy;
    logic [PCW-1:0]   r_pc;
    logic [PCW-1:0]   n_pc;
    pswa_pkg::t_uword w_rom;
    logic             w_last_go;

    function automatic pswa_pkg::t_uword uop(
        input logic              mul,
        input pswa_pkg::t_asel   a,
        input pswa_pkg::t_bsel   b,
        input pswa_pkg::t_accop  op,
        input pswa_pkg::t_addsel src,
        input pswa_pkg::t_addsh  sh,
        input logic              wv,
        input logic              wd,
        input logic              wi,
        input logic              jnc,
        input logic [PCW-1:0]    tgt,
        input logic              last
    );
        pswa_pkg::t_uword w;
        w.mul_en  = mul;
        w.a_sel   = a;
        w.b_sel   = b;
        w.acc_op  = op;
        w.add_sel = src;
        w.add_sh  = sh;
        w.wr_v    = wv;
        w.wr_d    = wd;
        w.wr_i    = wi;
        w.jmp_nc  = jnc;
        w.jmp_tgt = tgt;
        w.last    = last;
        return w;
    endfunction

    // control store; most products are registered and added in the step after the one issuing them
    always_comb begin
        case (r_pc)
            4'd0: w_rom = uop(1'b1, pswa_pkg::A_KSP, pswa_pkg::B_R, pswa_pkg::ACC_LOAD,
                              pswa_pkg::SRC_STATES, pswa_pkg::SH_0,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd1: w_rom = uop(1'b1, pswa_pkg::A_KPD, pswa_pkg::B_Y, pswa_pkg::ACC_ADD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_0,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd2: w_rom = uop(1'b1, pswa_pkg::A_DL, pswa_pkg::B_KF, pswa_pkg::ACC_SUB,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_0,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd3: w_rom = uop(1'b1, pswa_pkg::A_DH, pswa_pkg::B_KF, pswa_pkg::ACC_LOAD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_0,
                              1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd4: w_rom = uop(1'b1, pswa_pkg::A_KD, pswa_pkg::B_Y, pswa_pkg::ACC_ADD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_SPLIT,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd5: w_rom = uop(1'b1, pswa_pkg::A_KI, pswa_pkg::B_RMY, pswa_pkg::ACC_ADD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_FRAC,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            // product register holds the integral term across this step
            4'd6: w_rom = uop(1'b0, pswa_pkg::A_KSP, pswa_pkg::B_R, pswa_pkg::ACC_LOAD,
                              pswa_pkg::SRC_INTEG, pswa_pkg::SH_FRAC,
                              1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0);
            4'd7: w_rom = uop(1'b1, pswa_pkg::A_EL, pswa_pkg::B_KT, pswa_pkg::ACC_ADD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_FRAC,
                              1'b0, 1'b0, 1'b0, 1'b1, PC_INT_WB, 1'b0);
            4'd8: w_rom = uop(1'b1, pswa_pkg::A_EH, pswa_pkg::B_KT, pswa_pkg::ACC_ADD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_0,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd9: w_rom = uop(1'b0, pswa_pkg::A_KSP, pswa_pkg::B_R, pswa_pkg::ACC_ADD,
                              pswa_pkg::SRC_PROD, pswa_pkg::SH_SPLIT,
                              1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            4'd10: w_rom = uop(1'b0, pswa_pkg::A_KSP, pswa_pkg::B_R, pswa_pkg::ACC_NOP,
                               pswa_pkg::SRC_PROD, pswa_pkg::SH_0,
                               1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b1);
            default: w_rom = pswa_pkg::UW_NOP;
        endcase
    end

    assign w_last_go = r_busy && w_rom.last && i_out_free;

    always_comb begin
        if (!r_busy) begin
            n_pc = '0;
        end else if (w_rom.last) begin
            n_pc = i_out_free ? '0 : r_pc;
        end else if (w_rom.jmp_nc && !i_status.clamped) begin
            n_pc = w_rom.jmp_tgt;
        end else begin
            n_pc = r_pc + 1'b1;
        end
        n_busy = r_busy ? !w_last_go : i_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_uw   = r_busy ? w_rom : pswa_pkg::UW_NOP;
    assign o_busy = r_busy;
    assign o_done = w_last_go;

endmodule

@@ sv/pswa_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: shared multiplier, wide accumulator, controller state and output clamp.
module pswa_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pswa_pkg::t_uword                i_uw,
    input  pswa_pkg::t_coefs                i_coef,
    input  logic [pswa_pkg::SIG_W-1:0]      i_sp,
    input  logic [pswa_pkg::SIG_W-1:0]      i_ms,
    output pswa_pkg::t_dp_status            o_status
);

    localparam int SW    = pswa_pkg::SIG_W;
    localparam int FR    = pswa_pkg::FRAC;
    localparam int AW    = pswa_pkg::ACC_W;
    localparam int EWD   = pswa_pkg::EW;
    localparam int SP    = pswa_pkg::SPLIT;
    localparam int MA    = pswa_pkg::A_W;
    localparam int MB    = pswa_pkg::B_W;
    localparam int PW    = pswa_pkg::P_W;
    localparam int WW    = pswa_pkg::WIDE_W;
    localparam int QW    = SW + FR;
    localparam logic [EWD-1:0] HALF = EWD'(1) << (FR - 1);

    logic signed [MA-1:0]  w_a;
    logic signed [MB-1:0]  w_b;
    logic signed [SW:0]    w_rmy;
    logic signed [PW-1:0]  r_prod;
    logic signed [WW-1:0]  w_src;
    logic signed [WW-1:0]  w_add;
    logic signed [WW-1:0]  r_acc;
    logic signed [WW-1:0]  n_acc;
    logic signed [WW-1:0]  w_acc_sh;
    logic signed [AW-1:0]  r_v;
    logic signed [AW-1:0]  r_deriv;
    logic signed [AW-1:0]  r_integ;
    logic signed [EWD-1:0] r_e;
    logic signed [SW-1:0]  w_lo_in;
    logic signed [SW-1:0]  w_hi_in;
    logic signed [SW-1:0]  w_lo;
    logic signed [SW-1:0]  w_hi;
    logic signed [AW-1:0]  w_lo_q;
    logic signed [AW-1:0]  w_hi_q;
    logic signed [AW-1:0]  w_u;
    logic                  w_clamp;
    logic signed [EWD-1:0] w_e;
    logic [EWD-1:0]        w_round;
    logic [SW-1:0]         r_ctrl;
    logic                  r_clamp;

    assign w_rmy = (SW+1)'($signed(i_sp)) - (SW+1)'($signed(i_ms));

    always_comb begin
        case (i_uw.a_sel)
            pswa_pkg::A_KSP: w_a = MA'($signed(i_coef.ksp));
            pswa_pkg::A_KPD: w_a = MA'($signed(i_coef.kpd));
            pswa_pkg::A_KD:  w_a = MA'($signed(i_coef.kd));
            pswa_pkg::A_KI:  w_a = MA'($signed(i_coef.ki));
            pswa_pkg::A_DL:  w_a = MA'(r_deriv[SP-1:0]);
            pswa_pkg::A_DH:  w_a = MA'($signed(r_deriv[AW-1:SP]));
            pswa_pkg::A_EL:  w_a = MA'(r_e[SP-1:0]);
            pswa_pkg::A_EH:  w_a = MA'($signed(r_e[EWD-1:SP]));
            default:         w_a = '0;
        endcase
        case (i_uw.b_sel)
            pswa_pkg::B_R:   w_b = MB'($signed(i_sp));
            pswa_pkg::B_Y:   w_b = MB'($signed(i_ms));
            pswa_pkg::B_RMY: w_b = MB'(w_rmy);
            pswa_pkg::B_KF:  w_b = MB'(i_coef.kf);
            pswa_pkg::B_KT:  w_b = MB'(i_coef.kt);
            default:         w_b = '0;
        endcase
    end

    always_comb begin
        case (i_uw.add_sel)
            pswa_pkg::SRC_PROD:   w_src = WW'(r_prod);
            pswa_pkg::SRC_STATES: w_src = WW'(r_deriv) + WW'(r_integ);
            pswa_pkg::SRC_INTEG:  w_src = WW'(r_integ);
            default:              w_src = '0;
        endcase
        case (i_uw.add_sh)
            pswa_pkg::SH_0:     w_add = w_src;
            pswa_pkg::SH_FRAC:  w_add = w_src <<< FR;
            pswa_pkg::SH_SPLIT: w_add = w_src <<< SP;
            default:            w_add = w_src;
        endcase
        case (i_uw.acc_op)
            pswa_pkg::ACC_LOAD: n_acc = w_add;
            pswa_pkg::ACC_ADD:  n_acc = r_acc + w_add;
            pswa_pkg::ACC_SUB:  n_acc = r_acc - w_add;
            default:            n_acc = r_acc;
        endcase
    end

    assign w_acc_sh = r_acc >>> FR;

    // clamp against the ordered limits
    always_comb begin
        w_lo_in = $signed(i_coef.lo);
        w_hi_in = $signed(i_coef.hi);
        w_lo    = (w_lo_in > w_hi_in) ? w_hi_in : w_lo_in;
        w_hi    = (w_lo_in > w_hi_in) ? w_lo_in : w_hi_in;
        w_lo_q  = AW'($signed({w_lo, FR'(0)}));
        w_hi_q  = AW'($signed({w_hi, FR'(0)}));
        if (r_v < w_lo_q) begin
            w_u     = w_lo_q;
            w_clamp = 1'b1;
        end else if (r_v > w_hi_q) begin
            w_u     = w_hi_q;
            w_clamp = 1'b1;
        end else begin
            w_u     = r_v;
            w_clamp = 1'b0;
        end
        w_e     = EWD'(w_u) - EWD'(r_v);
        w_round = EWD'(w_u) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_uw.mul_en) begin
            r_prod <= w_a * w_b;
        end
        r_acc <= n_acc;
        if (i_uw.wr_v) begin
            r_v <= pswa_pkg::sat_acc(r_acc);
        end
        r_e     <= w_e;
        r_ctrl  <= w_round[QW-1:FR];
        r_clamp <= w_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deriv <= '0;
            r_integ <= '0;
        end else begin
            if (i_uw.wr_d) begin
                r_deriv <= pswa_pkg::sat_acc(w_acc_sh);
            end
            if (i_uw.wr_i) begin
                r_integ <= pswa_pkg::sat_acc(w_acc_sh);
            end
        end
    end

    assign o_status.control = r_ctrl;
    assign o_status.clamped = r_clamp;

endmodule

@@ sv/pid_setpoint_weighted_antiwindup_unit.sv @@
`timescale 1ns / 1ps
// Top level of the PID unit: configuration registers, handshakes and output register.
//
// Input channel: i_in_valid / o_in_stall carry one beat of setpoint and
// measurement; a beat is taken on an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry the control value and the
// clamp flag. Configuration: i_cfg_we writes i_cfg_data into register
// i_cfg_idx on the same edge; write only while no sample is in flight.
// A sample runs through a microcoded program on one shared 33x18 multiplier:
// 9 steps when the output stays inside the limits, 11 when it clamps (the
// tracking product takes two partial multiplies). The result is registered
// when its last step completes; the next beat is taken the cycle after, so
// no new beat is taken while a sample's program runs.
// The output register frees the sequencer: a new beat is taken while the last
// result waits. If that result is still stalled when the next one finishes,
// the sequencer holds on its last step and o_in_stall stays high.
// Reset clears the integral and derivative state, the gains and sets the
// limits to the full signal range.
module pid_setpoint_weighted_antiwindup_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pswa_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pswa_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [pswa_pkg::CFG_AW-1:0]      i_cfg_idx,
    input  logic [pswa_pkg::CFG_DW-1:0]      i_cfg_data
);

    localparam int SW  = pswa_pkg::SIG_W;
    localparam int KW  = pswa_pkg::KW;
    localparam int KSW = pswa_pkg::KSW;

    pswa_pkg::t_coefs     r_coef;
    logic [SW-1:0]        r_sp;
    logic [SW-1:0]        r_ms;
    logic                 r_out_valid;
    pswa_pkg::t_out_beat  r_out;
    pswa_pkg::t_uword     w_uw;
    pswa_pkg::t_dp_status w_status;
    logic                 w_busy;
    logic                 w_done;
    logic                 w_in_accept;
    logic                 w_out_free;

    assign w_in_accept = i_in_valid && !w_busy;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.ksp <= '0;
            r_coef.kpd <= '0;
            r_coef.kf  <= '0;
            r_coef.kd  <= '0;
            r_coef.ki  <= '0;
            r_coef.kt  <= '0;
            r_coef.lo  <= pswa_pkg::LO_LIM_RST;
            r_coef.hi  <= pswa_pkg::HI_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pswa_pkg::CFG_SP_GAIN:  r_coef.ksp <= i_cfg_data[KW-1:0];
                pswa_pkg::CFG_PD_GAIN:  r_coef.kpd <= i_cfg_data[KW-1:0];
                pswa_pkg::CFG_FILT:     r_coef.kf  <= i_cfg_data[KSW-1:0];
                pswa_pkg::CFG_D_GAIN:   r_coef.kd  <= i_cfg_data[KW-1:0];
                pswa_pkg::CFG_I_GAIN:   r_coef.ki  <= i_cfg_data[KW-1:0];
                pswa_pkg::CFG_TRK_GAIN: r_coef.kt  <= i_cfg_data[KSW-1:0];
                pswa_pkg::CFG_LO_LIM:   r_coef.lo  <= i_cfg_data[SW-1:0];
                pswa_pkg::CFG_HI_LIM:   r_coef.hi  <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sp <= i_in_data.setpoint;
            r_ms <= i_in_data.measurement;
        end
        if (w_done) begin
            r_out.control <= w_status.control;
            r_out.clamped <= w_status.clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    pswa_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_accept),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_uw       (w_uw),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    pswa_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uw     (w_uw),
        .i_coef   (r_coef),
        .i_sp     (r_sp),
        .i_ms     (r_ms),
        .o_status (w_status)
    );

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_done))
        else $error("output beat appeared without a finished program");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (w_busy && !w_done))
        else $error("accepted beat did not start a multi-step program");

    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_out_valid) |-> !i_out_stall)
        else $error("program finished into an occupied output register");

endmodule

@@ tb/pid_setpoint_weighted_antiwindup_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the PID unit: directed and random beats, fixed-point predictor.
module pid_setpoint_weighted_antiwindup_unit_tb;

    localparam int SIG_W  = pswa_pkg::SIG_W;
    localparam int FRAC   = pswa_pkg::FRAC;
    localparam int KW     = pswa_pkg::KW;
    localparam int KSW    = pswa_pkg::KSW;
    localparam int ACC_W  = pswa_pkg::ACC_W;
    localparam int CFG_AW = pswa_pkg::CFG_AW;
    localparam int CFG_DW = pswa_pkg::CFG_DW;

    typedef logic signed [95:0] t_wide;

    class pid_scoreboard;
        pswa_pkg::t_coefs    k;
        t_wide               integ;
        t_wide               deriv;
        pswa_pkg::t_out_beat expected_q[$];
        int                  errors;

        function new();
            k      = '0;
            k.lo   = pswa_pkg::LO_LIM_RST;
            k.hi   = pswa_pkg::HI_LIM_RST;
            integ  = '0;
            deriv  = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                pswa_pkg::CFG_SP_GAIN:  k.ksp = data[KW-1:0];
                pswa_pkg::CFG_PD_GAIN:  k.kpd = data[KW-1:0];
                pswa_pkg::CFG_FILT:     k.kf  = data[KSW-1:0];
                pswa_pkg::CFG_D_GAIN:   k.kd  = data[KW-1:0];
                pswa_pkg::CFG_I_GAIN:   k.ki  = data[KW-1:0];
                pswa_pkg::CFG_TRK_GAIN: k.kt  = data[KSW-1:0];
                pswa_pkg::CFG_LO_LIM:   k.lo  = data[SIG_W-1:0];
                pswa_pkg::CFG_HI_LIM:   k.hi  = data[SIG_W-1:0];
                default: ;
            endcase
        endfunction

        function t_wide sat_acc48(t_wide x);
            t_wide top;
            top = t_wide'(1) <<< (ACC_W - 1);
            if (x >= top) return top - 1;
            if (x < -top) return -top;
            return x;
        endfunction

        // coefficient times Q value, rounded toward minus infinity
        function t_wide scale_q(t_wide x, t_wide c);
            return (x * c) >>> FRAC;
        endfunction

        function void note_sample(pswa_pkg::t_in_beat b);
            t_wide               r, y, lo, hi, swap, lo_q, hi_q, v, u, kf, kt, ctl;
            pswa_pkg::t_out_beat e;
            r  = $signed(b.setpoint);
            y  = $signed(b.measurement);
            kf = k.kf;
            kt = k.kt;
            lo = $signed(k.lo);
            hi = $signed(k.hi);
            if (lo > hi) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            lo_q = lo <<< FRAC;
            hi_q = hi <<< FRAC;
            v = sat_acc48(sat_acc48($signed(k.ksp) * r) - sat_acc48($signed(k.kpd) * y)
                          + deriv + integ);
            u = v;
            e.clamped = 1'b0;
            if (v < lo_q) begin
                u = lo_q;
                e.clamped = 1'b1;
            end else if (v > hi_q) begin
                u = hi_q;
                e.clamped = 1'b1;
            end
            ctl = (u + (t_wide'(1) <<< (FRAC - 1))) >>> FRAC;
            e.control = ctl[SIG_W-1:0];
            deriv = sat_acc48(scale_q(deriv, kf) + sat_acc48($signed(k.kd) * y));
            integ = sat_acc48(integ + sat_acc48($signed(k.ki) * (r - y)) + scale_q(u - v, kt));
            expected_q.push_back(e);
        endfunction

        function void check_result(pswa_pkg::t_out_beat got);
            pswa_pkg::t_out_beat e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat: control %0d clamped %0b", $time,
                         $signed(got.control), got.clamped);
                return;
            end
            e = expected_q.pop_front();
            if (got.control !== e.control || got.clamped !== e.clamped) begin
                errors++;
                $display("%0t: expected control %0d clamped %0b, actual control %0d clamped %0b",
                         $time, $signed(e.control), e.clamped, $signed(got.control),
                         got.clamped);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    pswa_pkg::t_in_beat  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pswa_pkg::t_out_beat out_data;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_idx = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    logic [CFG_DW-1:0]   cfg_words [1 << CFG_AW];
    pswa_pkg::t_in_beat  batch[$];
    pid_scoreboard       sb;

    pid_setpoint_weighted_antiwindup_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function void add_beat(int sp, int ms);
        pswa_pkg::t_in_beat b;
        b.setpoint    = sp[SIG_W-1:0];
        b.measurement = ms[SIG_W-1:0];
        batch.push_back(b);
    endfunction

    task automatic apply_config();
        int i;
        for (i = 0; i < (1 << CFG_AW); i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_AW'(i);
            cfg_data <= cfg_words[i];
            @(posedge clk);
            sb.write_reg(CFG_AW'(i), cfg_words[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(input logic [CFG_DW-1:0] ksp, kpd, kf, kd, ki, kt, lo, hi);
        cfg_words[pswa_pkg::CFG_SP_GAIN]  = ksp;
        cfg_words[pswa_pkg::CFG_PD_GAIN]  = kpd;
        cfg_words[pswa_pkg::CFG_FILT]     = kf;
        cfg_words[pswa_pkg::CFG_D_GAIN]   = kd;
        cfg_words[pswa_pkg::CFG_I_GAIN]   = ki;
        cfg_words[pswa_pkg::CFG_TRK_GAIN] = kt;
        cfg_words[pswa_pkg::CFG_LO_LIM]   = lo;
        cfg_words[pswa_pkg::CFG_HI_LIM]   = hi;
        apply_config();
    endtask

    task automatic send_sample(input pswa_pkg::t_in_beat b, input bit drain);
        if (drain) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (sb.pending() != 0) @(posedge clk);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(b);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic run_batch(input int drain_at);
        foreach (batch[i]) send_sample(batch[i], i == drain_at);
        settle();
        batch.delete();
    endtask

    function logic [CFG_DW-1:0] rand_gain(int kind);
        int span;
        span = (kind == 0) ? 131072 : 4096;
        case (kind)
            2: return $urandom;
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return int'($urandom_range(2 * span)) - span;
        endcase
    endfunction

    // 17-bit coefficient with junk in the unused upper bits
    function logic [CFG_DW-1:0] rand_pole(int kind);
        logic [CFG_DW-1:0] v;
        case (kind)
            2: return $urandom;
            3: begin
                case ($urandom_range(2))
                    0: v = 0;
                    1: v = 65536;
                    default: v = 131071;
                endcase
            end
            default: v = $urandom_range(65536);
        endcase
        return (($urandom >> KSW) << KSW) | v;
    endfunction

    task automatic rand_config(input int kind);
        int a, c, t;
        case (kind)
            2: begin
                a = $urandom;
                c = $urandom;
            end
            3: begin
                a = $urandom_range(1) ? -32768 : 32767;
                c = $urandom_range(1) ? -32768 : 32767;
            end
            default: begin
                a = -int'($urandom_range(6000));
                c = $urandom_range(6000);
                if ($urandom_range(3) == 0) begin
                    t = a;
                    a = c;
                    c = t;
                end
                if ($urandom_range(19) == 0) c = a;
            end
        endcase
        set_cfg(rand_gain(kind), rand_gain(kind), rand_pole(kind), rand_gain(kind),
                rand_gain(kind), rand_pole(kind),
                (($urandom >> SIG_W) << SIG_W) | a[SIG_W-1:0],
                (($urandom >> SIG_W) << SIG_W) | c[SIG_W-1:0]);
    endtask

    // mostly setpoint steps with a drifting measurement, some raw noise
    task automatic make_batch(input int n);
        int i, sp, ms, run;
        run = 0;
        sp  = 0;
        ms  = 0;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15) begin
                add_beat($urandom, $urandom);
            end else begin
                if (run == 0) begin
                    sp  = ($urandom_range(4) == 0) ? int'($urandom_range(65535)) - 32768
                                                   : int'($urandom_range(8000)) - 4000;
                    run = $urandom_range(40, 5);
                end
                ms = ms + int'($urandom_range(400)) - 200;
                if ($urandom_range(9) == 0) ms = sp;
                if (ms > 32767) ms = 32767;
                if (ms < -32768) ms = -32768;
                add_beat(sp, ms);
                run--;
            end
        end
    endtask

    initial begin
        int p;
        sb = new();
        send_idle_pct <= 23;
        stall_pct     <= 61;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_beat(32767, -32768);
        add_beat(-32768, 32767);
        run_batch(-1);

        // halves round up
        set_cfg(32'h0000_8000, 0, 0, 0, 0, 0, 32'h0000_8000, 32'h0000_7FFF);
        add_beat(1, 0);
        add_beat(-1, 0);
        add_beat(3, 0);
        add_beat(-3, 0);
        run_batch(-1);

        set_cfg(32'h0001_0000, 32'h0001_8000, 32'hFFFE_C000, 32'h0000_4000,
                32'h0000_199A, 32'h0001_0000, 32'h1234_FC18, 32'h0000_03E8);
        add_beat(0, 0);
        add_beat(32767, -32768);
        add_beat(-32768, 32767);
        add_beat(100, 40);
        add_beat(100, 90);
        run_batch(-1);

        // inverted limits
        set_cfg(32'h0001_0000, 32'h0001_8000, 32'h0000_C000, 32'h0000_4000,
                32'h0000_199A, 32'h0001_0000, 32'h0000_01F4, 32'hFFFF_FE0C);
        add_beat(32767, 0);
        add_beat(-32768, 0);
        add_beat(0, 0);
        run_batch(-1);

        // equal limits
        set_cfg(32'h0001_0000, 32'h0001_8000, 32'h0000_C000, 32'h0000_4000,
                32'h0000_199A, 32'h0001_0000, 32'h0000_007B, 32'h0000_007B);
        add_beat(32767, -32768);
        add_beat(-5, 9);
        add_beat(0, 0);
        run_batch(-1);

        // largest gains, poles past their range
        set_cfg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h0001_FFFF, 32'hABCD_8000, 32'h0000_7FFF);
        add_beat(32767, -32768);
        add_beat(32767, -32768);
        add_beat(-32768, 32767);
        run_batch(-1);

        set_cfg(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000,
                32'h8000_0000, 32'h0001_0000, 32'h0000_7FFF, 32'h0000_8000);
        add_beat(-32768, 32767);
        add_beat(32767, -32768);
        add_beat(-32768, -32768);
        run_batch(-1);

        for (p = 0; p < 12; p++) begin
            send_idle_pct <= (p < 4) ? 23 : (p < 8) ? 61 : 0;
            stall_pct     <= (p < 4) ? 61 : (p < 8) ? 23 : 0;
            rand_config(p % 4);
            make_batch(130);
            run_batch($urandom_range(110, 20));
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
